### rtl/serial_flash_loader_protocol_core_assert.svh
// Assertion macros shared by the serial flash loader RTL
`ifndef SERIAL_FLASH_LOADER_PROTOCOL_CORE_ASSERT_SVH
`define SERIAL_FLASH_LOADER_PROTOCOL_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define SFL_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("serial flash loader assertion failed");

// next-cycle implication, sampled on aclk, off while aresetn is low
`define SFL_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("serial flash loader assertion failed");

`endif

### rtl/sfl_pkg.sv
// Shared constants, codes and types of the serial flash loader
package sfl_pkg;

    localparam int PAGE_BYTES = 32;
    localparam int IDX_W      = $clog2(PAGE_BYTES);
    localparam int CNT_W      = $clog2(PAGE_BYTES + 1);

    localparam int BYTE_INDEX_W = 5;
    localparam int M_TDATA_W    = 56;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [2:0] CFG_BOOT_DELAY   = 3'd0;
    localparam logic [2:0] CFG_BOOT_START   = 3'd1;
    localparam logic [2:0] CFG_OK_CODE      = 3'd2;
    localparam logic [2:0] CFG_CONFIRM_CODE = 3'd3;
    localparam logic [2:0] CFG_ACK_CODE     = 3'd4;
    localparam logic [2:0] CFG_ERROR_CODE   = 3'd5;

    typedef enum logic [5:0] {
        PH_FIRST   = 6'b000001,
        PH_CONFIRM = 6'b000010,
        PH_ADDR    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_DONE    = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        SEQ_IDLE = 3'b001,
        SEQ_PAGE = 3'b010,
        SEQ_TAIL = 3'b100
    } seq_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } pb_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
    } pb_rd_t;

endpackage

### rtl/sfl_page_buf.sv
// Page buffer memory with registered read and erased-byte fill beyond the count
module sfl_page_buf (
    input  logic           aclk,
    input  sfl_pkg::pb_wr_t wr,
    input  sfl_pkg::pb_rd_t rd,
    output logic [7:0]     rd_byte
);
    import sfl_pkg::*;

    logic [7:0] mem [PAGE_BYTES];
    logic [7:0] rd_byte_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.idx] <= wr.data;
        end
        if (rd.en) begin
            rd_byte_reg <= (CNT_W'(rd.idx) < rd.count) ? mem[rd.idx] : ERASED_BYTE;
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

### rtl/serial_flash_loader_protocol_core.sv
// Serial flash loader handshake: tick and byte items in, reply, page data and start items out.
// An input item is taken whenever the sequencer is idle. An item that causes a
// reply or a start-application item holds off the next item until the last of
// those is loaded into the output register, which waits while the output stalls.
// An item that completes a page, or ends the data on a partial page, streams all 32 page
// bytes from the page memory's single read port at one per cycle while the output does not
// stall, then the reply, and start-application when the data has ended. The page buffer
// is cleared by a fill count, so bytes past it read as erased and there is no clearing pass.
`include "serial_flash_loader_protocol_core_assert.svh"

module serial_flash_loader_protocol_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // rx_byte
    input  logic                          s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // reply_byte, page_address, byte_index, page_byte, zero pad
    output logic [sfl_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [1:0]                    m_tuser,   // kind
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);
    import sfl_pkg::*;

    logic [15:0] boot_delay_reg;
    logic [31:0] boot_start_reg;
    logic [7:0]  ok_code_reg, confirm_code_reg, ack_code_reg, error_code_reg;

    phase_t           phase_reg, phase_next;
    seq_t             seq_reg, seq_next;
    logic [15:0]      window_reg, window_next;
    logic [31:0]      load_addr_reg, load_addr_next;
    logic [31:0]      load_len_reg, load_len_next;
    logic [1:0]       wbc_reg, wbc_next;
    logic [31:0]      bytes_rx_reg, bytes_rx_next;
    logic [31:0]      page_off_reg, page_off_next;
    logic [IDX_W-1:0] fill_reg, fill_next;

    logic             rep_pend_reg, rep_pend_next;
    logic             start_pend_reg, start_pend_next;
    logic [7:0]       rep_byte_reg, rep_byte_next;
    logic [31:0]      page_addr_reg, page_addr_next;
    logic [CNT_W-1:0] page_cnt_reg, page_cnt_next;
    logic [CNT_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic             q_valid_reg, q_valid_next;
    logic [IDX_W-1:0] q_idx_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_kind_reg, out_kind_next;
    logic [7:0]              out_reply_reg, out_reply_next;
    logic [31:0]             out_addr_reg, out_addr_next;
    logic [BYTE_INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic [7:0]              out_pb_reg, out_pb_next;
    logic                    out_last_reg, out_last_next;

    logic   acc, slot_free, q_move;
    pb_wr_t wr;
    pb_rd_t rd;
    logic [7:0] rd_byte;

    sfl_page_buf u_page_buf (
        .aclk    (aclk),
        .wr      (wr),
        .rd      (rd),
        .rd_byte (rd_byte)
    );

    assign s_tready  = (seq_reg == SEQ_IDLE);
    assign acc       = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign slot_free = !out_valid_reg || m_tready;
    assign q_move    = (seq_reg == SEQ_PAGE) && q_valid_reg && slot_free;

    assign rd.en    = (seq_reg == SEQ_PAGE) && (rd_cnt_reg != CNT_W'(PAGE_BYTES))
                      && (!q_valid_reg || q_move);
    assign rd.idx   = rd_cnt_reg[IDX_W-1:0];
    assign rd.count = page_cnt_reg;

    always_comb begin
        logic [15:0] wt_inc;
        logic [31:0] word_next;
        logic        full;

        phase_next      = phase_reg;
        seq_next        = seq_reg;
        window_next     = window_reg;
        load_addr_next  = load_addr_reg;
        load_len_next   = load_len_reg;
        wbc_next        = wbc_reg;
        bytes_rx_next   = bytes_rx_reg;
        page_off_next   = page_off_reg;
        fill_next       = fill_reg;
        rep_pend_next   = rep_pend_reg;
        start_pend_next = start_pend_reg;
        rep_byte_next   = rep_byte_reg;
        page_addr_next  = page_addr_reg;
        page_cnt_next   = page_cnt_reg;
        rd_cnt_next     = rd_cnt_reg;
        q_valid_next    = q_valid_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_reply_next  = out_reply_reg;
        out_addr_next   = out_addr_reg;
        out_idx_next    = out_idx_reg;
        out_pb_next     = out_pb_reg;
        out_last_next   = out_last_reg;
        wr              = '0;
        wt_inc          = (window_reg != 16'hFFFF) ? window_reg + 16'd1 : window_reg;
        word_next       = 32'd0;
        full            = 1'b0;

        if (acc) begin
            case (phase_reg)
                PH_FIRST, PH_CONFIRM: begin
                    if (!s_tuser) begin
                        window_next = wt_inc;
                        if (wt_inc >= boot_delay_reg) begin
                            start_pend_next = 1'b1;
                            phase_next      = PH_DONE;
                        end
                    end else if (window_reg >= boot_delay_reg) begin
                        start_pend_next = 1'b1;
                        phase_next      = PH_DONE;
                    end else if (phase_reg == PH_FIRST) begin
                        rep_pend_next = 1'b1;
                        rep_byte_next = ok_code_reg;
                        phase_next    = PH_CONFIRM;
                        window_next   = 16'd0;
                    end else if (s_tdata == confirm_code_reg) begin
                        rep_pend_next = 1'b1;
                        rep_byte_next = ack_code_reg;
                        phase_next    = PH_ADDR;
                        wbc_next      = 2'd0;
                    end
                end
                PH_ADDR: begin
                    if (s_tuser) begin
                        load_addr_next = {load_addr_reg[23:0], s_tdata};
                        wbc_next       = wbc_reg + 2'd1;
                        if (wbc_next == 2'd0) begin
                            rep_pend_next = 1'b1;
                            rep_byte_next = ok_code_reg;
                            phase_next    = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    if (s_tuser) begin
                        word_next     = {load_len_reg[23:0], s_tdata};
                        load_len_next = word_next;
                        wbc_next      = wbc_reg + 2'd1;
                        if (wbc_next == 2'd0) begin
                            rep_pend_next = 1'b1;
                            rep_byte_next = (load_addr_reg + word_next >= boot_start_reg)
                                            ? error_code_reg : ok_code_reg;
                            bytes_rx_next = 32'd0;
                            page_off_next = 32'd0;
                            fill_next     = '0;
                            if (word_next == 32'd0) begin
                                start_pend_next = 1'b1;
                                phase_next      = PH_DONE;
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    if (s_tuser) begin
                        wr.en         = 1'b1;
                        wr.idx        = fill_reg;
                        wr.data       = s_tdata;
                        bytes_rx_next = bytes_rx_reg + 32'd1;
                        if (fill_reg == IDX_W'(PAGE_BYTES - 1)) begin
                            full           = 1'b1;
                            fill_next      = '0;
                            rep_pend_next  = 1'b1;
                            rep_byte_next  = ok_code_reg;
                            page_addr_next = load_addr_reg + page_off_reg;
                            page_cnt_next  = CNT_W'(PAGE_BYTES);
                            page_off_next  = page_off_reg + 32'(PAGE_BYTES);
                            rd_cnt_next    = '0;
                            seq_next       = SEQ_PAGE;
                        end else begin
                            fill_next = fill_reg + 1'b1;
                        end
                        if (bytes_rx_next >= load_len_reg) begin
                            if (!full) begin
                                rep_pend_next  = 1'b1;
                                rep_byte_next  = ok_code_reg;
                                page_addr_next = load_addr_reg + page_off_reg;
                                page_cnt_next  = CNT_W'(fill_reg) + 1'b1;
                                rd_cnt_next    = '0;
                                seq_next       = SEQ_PAGE;
                            end
                            start_pend_next = 1'b1;
                            phase_next      = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase
            if (seq_next == SEQ_IDLE && (rep_pend_next || start_pend_next)) begin
                seq_next = SEQ_TAIL;
            end
        end

        if (rd.en) begin
            rd_cnt_next = rd_cnt_reg + 1'b1;
        end
        q_valid_next = rd.en ? 1'b1 : (q_move ? 1'b0 : q_valid_reg);

        if (q_move) begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_DATA;
            out_reply_next = 8'd0;
            out_addr_next  = page_addr_reg;
            out_idx_next   = BYTE_INDEX_W'(q_idx_reg);
            out_pb_next    = rd_byte;
            out_last_next  = 1'b0;
        end else if (seq_reg == SEQ_TAIL && slot_free) begin
            out_valid_next = 1'b1;
            out_addr_next  = 32'd0;
            out_idx_next   = '0;
            out_pb_next    = 8'd0;
            if (rep_pend_reg) begin
                out_kind_next  = KIND_REPLY;
                out_reply_next = rep_byte_reg;
                out_last_next  = !start_pend_reg;
                rep_pend_next  = 1'b0;
                if (!start_pend_reg) begin
                    seq_next = SEQ_IDLE;
                end
            end else begin
                out_kind_next   = KIND_START;
                out_reply_next  = 8'd0;
                out_last_next   = 1'b1;
                start_pend_next = 1'b0;
                seq_next        = SEQ_IDLE;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        if (seq_reg == SEQ_PAGE && rd_cnt_reg == CNT_W'(PAGE_BYTES) && !q_valid_reg) begin
            seq_next = SEQ_TAIL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            boot_delay_reg   <= 16'd1000;
            boot_start_reg   <= 32'd28672;
            ok_code_reg      <= 8'd111;
            confirm_code_reg <= 8'd99;
            ack_code_reg     <= 8'd97;
            error_code_reg   <= 8'd101;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_BOOT_DELAY:   boot_delay_reg   <= cfg_data[15:0];
                CFG_BOOT_START:   boot_start_reg   <= cfg_data;
                CFG_OK_CODE:      ok_code_reg      <= cfg_data[7:0];
                CFG_CONFIRM_CODE: confirm_code_reg <= cfg_data[7:0];
                CFG_ACK_CODE:     ack_code_reg     <= cfg_data[7:0];
                CFG_ERROR_CODE:   error_code_reg   <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_FIRST;
            seq_reg        <= SEQ_IDLE;
            window_reg     <= 16'd0;
            load_addr_reg  <= 32'd0;
            load_len_reg   <= 32'd0;
            wbc_reg        <= 2'd0;
            bytes_rx_reg   <= 32'd0;
            page_off_reg   <= 32'd0;
            fill_reg       <= '0;
            rep_pend_reg   <= 1'b0;
            start_pend_reg <= 1'b0;
            rd_cnt_reg     <= '0;
            q_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
            window_reg     <= window_next;
            load_addr_reg  <= load_addr_next;
            load_len_reg   <= load_len_next;
            wbc_reg        <= wbc_next;
            bytes_rx_reg   <= bytes_rx_next;
            page_off_reg   <= page_off_next;
            fill_reg       <= fill_next;
            rep_pend_reg   <= rep_pend_next;
            start_pend_reg <= start_pend_next;
            rd_cnt_reg     <= rd_cnt_next;
            q_valid_reg    <= q_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_byte_reg  <= rep_byte_next;
        page_addr_reg <= page_addr_next;
        page_cnt_reg  <= page_cnt_next;
        out_kind_reg  <= out_kind_next;
        out_reply_reg <= out_reply_next;
        out_addr_reg  <= out_addr_next;
        out_idx_reg   <= out_idx_next;
        out_pb_reg    <= out_pb_next;
        out_last_reg  <= out_last_next;
        if (rd.en) begin
            q_idx_reg <= rd.idx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_pb_reg, out_idx_reg, out_addr_reg, out_reply_reg};

    `SFL_ASSERT_IMP(a_q_only_in_page, q_valid_reg, seq_reg == SEQ_PAGE)
    `SFL_ASSERT_NXT(a_q_move_loads_data, q_move, m_tvalid && m_tuser == KIND_DATA)
    `SFL_ASSERT_IMP(a_data_never_last, m_tvalid && m_tuser == KIND_DATA, !m_tlast)
    `SFL_ASSERT_IMP(a_start_means_done, m_tvalid && m_tuser == KIND_START, phase_reg == PH_DONE)
    `SFL_ASSERT_IMP(a_rd_cnt_bound, seq_reg == SEQ_PAGE, rd_cnt_reg <= CNT_W'(PAGE_BYTES))

endmodule
